### rtl/fpac_pkg.sv
// Package for the framebuffer pixel access block: register map, pipeline control
// type and the reciprocal table used by the channel scaler.
// Depends on nothing; every other file imports it.
`default_nettype none

package fpac_pkg;

  // Register map, one register per 32-bit word.
  localparam int unsigned RegIdxW  = 3;
  localparam int unsigned PaddrW   = 5;

  typedef enum logic [RegIdxW-1:0] {
    REG_BASE_ADDRESS    = 3'd0,
    REG_LINE_PITCH      = 3'd1,
    REG_SCREEN_WIDTH    = 3'd2,
    REG_SCREEN_HEIGHT   = 3'd3,
    REG_PIXEL_BYTES     = 3'd4,
    REG_RED_LAYOUT      = 3'd5,
    REG_GREEN_LAYOUT    = 3'd6,
    REG_BLUE_LAYOUT     = 3'd7
  } reg_idx_t;

  // Legal pixel sizes in bytes.
  localparam logic [2:0] BppThree = 3'd3;
  localparam logic [2:0] BppFour  = 3'd4;

  // Channel sizes run from one to eight bits.
  localparam logic [3:0] ChanSizeMin = 4'd1;
  localparam logic [3:0] ChanSizeMax = 4'd8;

  // Fixed-point precision of the reciprocal table.
  localparam int unsigned RecipFrac = 24;
  localparam int unsigned RecipW    = RecipFrac + 1;

  // Stage enables of the three-stage pipeline.
  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
  } pipe_ctl_t;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic [31:0] base_address;
    logic [15:0] line_pitch;
    logic [13:0] screen_width;
    logic [13:0] screen_height;
    logic [2:0]  pixel_bytes;
    logic [8:0]  red_layout;
    logic [8:0]  green_layout;
    logic [8:0]  blue_layout;
  } cfg_t;

  // floor(2^24 / (2^size - 1)) for each legal channel size.
  function automatic logic [RecipW-1:0] recip_lookup(input logic [3:0] size);
    logic [RecipW-1:0] r;
    case (size)
      4'd1:    r = 25'd16777216;
      4'd2:    r = 25'd5592405;
      4'd3:    r = 25'd2396745;
      4'd4:    r = 25'd1118481;
      4'd5:    r = 25'd541200;
      4'd6:    r = 25'd266305;
      4'd7:    r = 25'd132104;
      4'd8:    r = 25'd65793;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/framebuffer_pixel_access_convert_core.sv
// Framebuffer pixel access unit.
// Inputs take one item (a pixel write or read at signed x_pos, y_pos) with
// valid and ready; results leave on the output channel with the same handshake.
// The unit clips the coordinate, checks the configuration, forms the byte
// address base + y*pitch + x*bytes, packs RGB888 into the native word on
// writes and unpacks and scales native channels to RGB888 on reads.
// Stage one captures an item at its accepting edge; the item then moves on
// through stage two into stage three, whose registers drive the result.
// Throughput is one item per cycle unless the receiver stalls; the pipeline is
// three register stages, set by the pitch multiply, the address add with the
// reciprocal multiply, and the quotient correction of the channel scaler.
// When the receiver stalls, each stage holds and a stage with no item fills,
// so up to three items are held before input ready drops; nothing is lost.
// Reset clears the stage valid bits and all configuration registers. The
// reset configuration is invalid, so every access gives access_ok 0 until
// software programs the registers over the APB-style port, while idle.
// Depends on fpac_pkg, fpac_regs and fpac_chan.
`default_nettype none

module framebuffer_pixel_access_convert_core (
  input  logic                        clk,
  input  logic                        rst,
  // Configuration port.
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fpac_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  // Input channel.
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        func,
  input  logic signed [15:0]          x_pos,
  input  logic signed [15:0]          y_pos,
  input  logic [23:0]                 color_in,
  input  logic [31:0]                 pixel_in,
  // Output channel.
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [32:0]                 byte_address,
  output logic [31:0]                 pixel_out,
  output logic [2:0]                  byte_count,
  output logic                        access_ok,
  output logic [23:0]                 color_out
);
  import fpac_pkg::*;

  cfg_t      cfg;
  pipe_ctl_t ctl;

  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3;

  // Stage one combinational checks.
  logic        size_ok;
  logic        cfg_ok;
  logic        x_ok, y_ok;
  logic [31:0] bmask;
  logic [31:0] native_rd;
  logic [31:0] pk_r, pk_g, pk_b;
  logic [7:0]  sc_r, sc_g, sc_b;

  // Stage registers.
  logic        func1, ok1;
  logic [29:0] prod_y1;
  logic [16:0] x_off1;
  logic [31:0] pix1;
  logic [2:0]  bpp1;

  logic        func2, ok2;
  logic [32:0] addr2;
  logic [31:0] pix2;
  logic [2:0]  bpp2;

  logic        func3, ok3;
  logic [32:0] addr3;
  logic [31:0] pix3;
  logic [2:0]  bpp3;

  fpac_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // A stage moves on when it is empty or the stage after it moves.
  assign rdy3     = !v3 || out_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;
  assign ctl      = '{en1: rdy1, en2: rdy2, en3: rdy3};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  // Configuration and clipping checks.
  assign size_ok = (cfg.red_layout[3:0]   >= ChanSizeMin) && (cfg.red_layout[3:0]   <= ChanSizeMax)
                && (cfg.green_layout[3:0] >= ChanSizeMin) && (cfg.green_layout[3:0] <= ChanSizeMax)
                && (cfg.blue_layout[3:0]  >= ChanSizeMin) && (cfg.blue_layout[3:0]  <= ChanSizeMax);
  assign cfg_ok  = (cfg.base_address != '0) && (cfg.screen_width != '0)
                && (cfg.screen_height != '0) && size_ok
                && ((cfg.pixel_bytes == BppThree) || (cfg.pixel_bytes == BppFour));
  assign x_ok    = !x_pos[15] && (x_pos[14:0] < {1'b0, cfg.screen_width});
  assign y_ok    = !y_pos[15] && (y_pos[14:0] < {1'b0, cfg.screen_height});

  assign bmask     = (cfg.pixel_bytes == BppFour) ? 32'hFFFF_FFFF : 32'h00FF_FFFF;
  assign native_rd = pixel_in & bmask;

  fpac_chan u_red (
    .clk         (clk),
    .ctl         (ctl),
    .layout      (cfg.red_layout),
    .native      (native_rd),
    .color8      (color_in[23:16]),
    .packed_word (pk_r),
    .scaled      (sc_r)
  );

  fpac_chan u_green (
    .clk         (clk),
    .ctl         (ctl),
    .layout      (cfg.green_layout),
    .native      (native_rd),
    .color8      (color_in[15:8]),
    .packed_word (pk_g),
    .scaled      (sc_g)
  );

  fpac_chan u_blue (
    .clk         (clk),
    .ctl         (ctl),
    .layout      (cfg.blue_layout),
    .native      (native_rd),
    .color8      (color_in[7:0]),
    .packed_word (pk_b),
    .scaled      (sc_b)
  );

  // Payload stages; offsets use the low coordinate bits, valid when in range.
  always_ff @(posedge clk) begin
    if (ctl.en1) begin
      func1   <= func;
      ok1     <= cfg_ok && x_ok && y_ok;
      prod_y1 <= y_pos[13:0] * cfg.line_pitch;
      x_off1  <= x_pos[13:0] * cfg.pixel_bytes;
      pix1    <= (pk_r | pk_g | pk_b) & bmask;
      bpp1    <= cfg.pixel_bytes;
    end
    if (ctl.en2) begin
      func2 <= func1;
      ok2   <= ok1;
      addr2 <= {1'b0, cfg.base_address} + {3'd0, prod_y1} + {16'd0, x_off1};
      pix2  <= pix1;
      bpp2  <= bpp1;
    end
    if (ctl.en3) begin
      func3 <= func2;
      ok3   <= ok2;
      addr3 <= addr2;
      pix3  <= pix2;
      bpp3  <= bpp2;
    end
  end

  // Result fields read zero when the access is refused.
  assign out_valid    = v3;
  assign access_ok    = ok3;
  assign byte_address = ok3 ? addr3 : '0;
  assign byte_count   = ok3 ? bpp3 : '0;
  assign pixel_out    = (ok3 && !func3) ? pix3 : '0;
  assign color_out    = (ok3 && func3) ? {sc_r, sc_g, sc_b} : '0;

endmodule

`default_nettype wire

### rtl/fpac_regs.sv
// Configuration register file with its APB-style write and read port.
// Depends on fpac_pkg for the register map and the configuration struct.
`default_nettype none

module fpac_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fpac_pkg::PaddrW-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output fpac_pkg::cfg_t                cfg
);
  import fpac_pkg::*;

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[PaddrW-1:2]);
  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite & pready;

  // Register writes at the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr) begin
      case (idx)
        REG_BASE_ADDRESS:    cfg.base_address    <= pwdata;
        REG_LINE_PITCH:      cfg.line_pitch      <= pwdata[15:0];
        REG_SCREEN_WIDTH:    cfg.screen_width    <= pwdata[13:0];
        REG_SCREEN_HEIGHT:   cfg.screen_height   <= pwdata[13:0];
        REG_PIXEL_BYTES:     cfg.pixel_bytes     <= pwdata[2:0];
        REG_RED_LAYOUT:      cfg.red_layout      <= pwdata[8:0];
        REG_GREEN_LAYOUT:    cfg.green_layout    <= pwdata[8:0];
        REG_BLUE_LAYOUT:     cfg.blue_layout     <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  // Read data follows the address.
  always_comb begin
    case (idx)
      REG_BASE_ADDRESS:    prdata = cfg.base_address;
      REG_LINE_PITCH:      prdata = {16'd0, cfg.line_pitch};
      REG_SCREEN_WIDTH:    prdata = {18'd0, cfg.screen_width};
      REG_SCREEN_HEIGHT:   prdata = {18'd0, cfg.screen_height};
      REG_PIXEL_BYTES:     prdata = {29'd0, cfg.pixel_bytes};
      REG_RED_LAYOUT:      prdata = {23'd0, cfg.red_layout};
      REG_GREEN_LAYOUT:    prdata = {23'd0, cfg.green_layout};
      REG_BLUE_LAYOUT:     prdata = {23'd0, cfg.blue_layout};
      default:             prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### rtl/fpac_chan.sv
// One color channel: packs an 8-bit value into the native word and unpacks,
// then scales a native field to 0..255 over three pipeline stages.
// Depends on fpac_pkg for the stage enables and the reciprocal table.
`default_nettype none

module fpac_chan (
  input  logic                clk,
  input  fpac_pkg::pipe_ctl_t ctl,
  input  logic [8:0]          layout,
  input  logic [31:0]         native,
  input  logic [7:0]          color8,
  output logic [31:0]         packed_word,
  output logic [7:0]          scaled
);
  import fpac_pkg::*;

  logic [4:0]  pos;
  logic [3:0]  size;
  logic [3:0]  trunc_sh;
  logic [7:0]  field_mask;
  logic [7:0]  field;
  logic [15:0] n_comb;

  // Stage registers.
  logic [15:0]               n1;
  logic [3:0]                s1;
  logic [15:0]               n2;
  logic [3:0]                s2;
  logic [RecipW+15:0]        prod2;

  // Stage three correction terms.
  logic [7:0]  q_est;
  logic [16:0] qm;
  logic [16:0] rem;
  logic [16:0] m;

  assign pos  = layout[8:4];
  assign size = layout[3:0];

  // Write path: keep the top size bits and move them to the field position.
  assign trunc_sh    = 4'(ChanSizeMax - size);
  assign packed_word = ({24'd0, color8} >> trunc_sh) << pos;

  // Read path: extract the field and form value*255 as (value<<8) - value.
  assign field_mask = 8'((9'd1 << size) - 9'd1);
  assign field      = 8'(native >> pos) & field_mask;
  assign n_comb     = {field, 8'd0} - {8'd0, field};

  // Stage one holds the numerator, stage two the reciprocal product.
  always_ff @(posedge clk) begin
    if (ctl.en1) begin
      n1 <= n_comb;
      s1 <= size;
    end
    if (ctl.en2) begin
      n2    <= n1;
      s2    <= s1;
      prod2 <= n1 * recip_lookup(s1);
    end
  end

  // The estimate is at most one low; one compare and add fixes it.
  assign q_est = prod2[RecipFrac+7:RecipFrac];
  assign qm    = ({9'd0, q_est} << s2) - {9'd0, q_est};
  assign rem   = {1'b0, n2} - qm;
  assign m     = (17'd1 << s2) - 17'd1;

  always_ff @(posedge clk) begin
    if (ctl.en3) begin
      scaled <= (rem >= m) ? q_est + 8'd1 : q_est;
    end
  end

endmodule

`default_nettype wire
